// ===== hdl/stt_pkg.sv =====
// shared types, token codes and character classes for the source text tokenizer
package stt_pkg;

  localparam int KEYWORD_MAX_LEN_DEF = 8;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int LINE_BITS_DEF = 24;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 24;
  localparam int MAX_RESULTS = 3;

  typedef logic [6:0] kind_t;

  localparam kind_t K_NONE = 7'd0;
  localparam kind_t K_BOOL = 7'd27;
  localparam kind_t K_INT = 7'd28;
  localparam kind_t K_FLOAT = 7'd29;
  localparam kind_t K_STRING = 7'd30;
  localparam kind_t K_CHAR = 7'd31;
  localparam kind_t K_IDENT = 7'd32;
  localparam kind_t K_LPAREN = 7'd33;
  localparam kind_t K_RPAREN = 7'd34;
  localparam kind_t K_LBRACE = 7'd35;
  localparam kind_t K_RBRACE = 7'd36;
  localparam kind_t K_LBRACKET = 7'd37;
  localparam kind_t K_RBRACKET = 7'd38;
  localparam kind_t K_COMMA = 7'd39;
  localparam kind_t K_SEMI = 7'd40;
  localparam kind_t K_DOT = 7'd41;
  localparam kind_t K_DOTDOT = 7'd42;
  localparam kind_t K_AT = 7'd43;
  localparam kind_t K_COLON = 7'd44;
  localparam kind_t K_COLONEQ = 7'd45;
  localparam kind_t K_ARROW = 7'd46;
  localparam kind_t K_MINUSEQ = 7'd47;
  localparam kind_t K_MINUS = 7'd48;
  localparam kind_t K_PLUSEQ = 7'd49;
  localparam kind_t K_PLUS = 7'd50;
  localparam kind_t K_STAREQ = 7'd51;
  localparam kind_t K_STAR = 7'd52;
  localparam kind_t K_SLASHEQ = 7'd53;
  localparam kind_t K_SLASH = 7'd54;
  localparam kind_t K_PCTEQ = 7'd55;
  localparam kind_t K_PCT = 7'd56;
  localparam kind_t K_EQEQ = 7'd57;
  localparam kind_t K_FATARROW = 7'd58;
  localparam kind_t K_EQ = 7'd59;
  localparam kind_t K_BANGEQ = 7'd60;
  localparam kind_t K_BANG = 7'd61;
  localparam kind_t K_SHLEQ = 7'd62;
  localparam kind_t K_SHL = 7'd63;
  localparam kind_t K_LE = 7'd64;
  localparam kind_t K_LT = 7'd65;
  localparam kind_t K_SHREQ = 7'd66;
  localparam kind_t K_SHR = 7'd67;
  localparam kind_t K_GE = 7'd68;
  localparam kind_t K_GT = 7'd69;
  localparam kind_t K_ANDAND = 7'd70;
  localparam kind_t K_AMPEQ = 7'd71;
  localparam kind_t K_AMP = 7'd72;
  localparam kind_t K_OROR = 7'd73;
  localparam kind_t K_PIPEEQ = 7'd74;
  localparam kind_t K_PIPE = 7'd75;
  localparam kind_t K_CARETEQ = 7'd76;
  localparam kind_t K_CARET = 7'd77;
  localparam kind_t K_TILDE = 7'd78;
  localparam kind_t K_DOC = 7'd79;
  localparam kind_t K_EOF = 7'd80;
  localparam kind_t K_ERROR = 7'd81;

  typedef enum logic [32:0] {
    M_IDLE      = 33'b1 << 0,
    M_IDENT     = 33'b1 << 1,
    M_ZERO      = 33'b1 << 2,
    M_DEC       = 33'b1 << 3,
    M_DECDOT    = 33'b1 << 4,
    M_FRAC      = 33'b1 << 5,
    M_EXPSIGN   = 33'b1 << 6,
    M_EXPDIG    = 33'b1 << 7,
    M_SUFFIX    = 33'b1 << 8,
    M_PREFIXED  = 33'b1 << 9,
    M_STR       = 33'b1 << 10,
    M_CHR       = 33'b1 << 11,
    M_SLASH     = 33'b1 << 12,
    M_SLASH2    = 33'b1 << 13,
    M_LINECOM   = 33'b1 << 14,
    M_DOC       = 33'b1 << 15,
    M_BLOCK     = 33'b1 << 16,
    M_BLOCKSTAR = 33'b1 << 17,
    M_DOT       = 33'b1 << 18,
    M_COLON     = 33'b1 << 19,
    M_MINUS     = 33'b1 << 20,
    M_PLUS      = 33'b1 << 21,
    M_STAR      = 33'b1 << 22,
    M_PCT       = 33'b1 << 23,
    M_EQ        = 33'b1 << 24,
    M_BANG      = 33'b1 << 25,
    M_LT        = 33'b1 << 26,
    M_GT        = 33'b1 << 27,
    M_AMP       = 33'b1 << 28,
    M_PIPE      = 33'b1 << 29,
    M_CARET     = 33'b1 << 30,
    M_SHL       = 33'b1 << 31,
    M_SHR       = 33'b1 << 32
  } mode_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return is_digit(c) || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // keyword buffer holds the first byte in its low bits, so the texts are reversed
  function automatic kind_t kw_kind(input logic [63:0] b);
    case (b)
      64'("nf"):       return 7'd0;
      64'("bup"):      return 7'd1;
      64'("ter"):      return 7'd2;
      64'("tel"):      return 7'd3;
      64'("rav"):      return 7'd4;
      64'("fer"):      return 7'd5;
      64'("tum"):      return 7'd6;
      64'("tsnoc"):    return 7'd7;
      64'("fi"):       return 7'd8;
      64'("esle"):     return 7'd9;
      64'("pool"):     return 7'd10;
      64'("elihw"):    return 7'd11;
      64'("kaerb"):    return 7'd12;
      64'("eunitnoc"): return 7'd13;
      64'("hctam"):    return 7'd14;
      64'("tcurts"):   return 7'd15;
      64'("mune"):     return 7'd16;
      64'("epyt"):     return 7'd17;
      64'("anera"):    return 7'd18;
      64'("efasnu"):   return 7'd19;
      64'("eruces"):   return 7'd20;
      64'("esu"):      return 7'd21;
      64'("dom"):      return 7'd22;
      64'("emitpmoc"): return 7'd23;
      64'("enilni"):   return 7'd24;
      64'("tiart"):    return 7'd25;
      64'("lpmi"):     return 7'd26;
      64'("eurt"):     return K_BOOL;
      64'("eslaf"):    return K_BOOL;
      default:         return K_IDENT;
    endcase
  endfunction

  function automatic kind_t op_single(input mode_t m);
    case (m)
      M_DOT:   return K_DOT;
      M_COLON: return K_COLON;
      M_MINUS: return K_MINUS;
      M_PLUS:  return K_PLUS;
      M_STAR:  return K_STAR;
      M_PCT:   return K_PCT;
      M_EQ:    return K_EQ;
      M_BANG:  return K_BANG;
      M_LT:    return K_LT;
      M_GT:    return K_GT;
      M_AMP:   return K_AMP;
      M_PIPE:  return K_PIPE;
      M_SLASH: return K_SLASH;
      default: return K_CARET;
    endcase
  endfunction

  // two-byte operator, K_NONE when the pair forms none
  function automatic kind_t op_pair(input mode_t m, input logic [7:0] c);
    case (m)
      M_DOT:   return c == "." ? K_DOTDOT : K_NONE;
      M_COLON: return c == "=" ? K_COLONEQ : K_NONE;
      M_MINUS: return c == ">" ? K_ARROW : (c == "=" ? K_MINUSEQ : K_NONE);
      M_PLUS:  return c == "=" ? K_PLUSEQ : K_NONE;
      M_STAR:  return c == "=" ? K_STAREQ : K_NONE;
      M_PCT:   return c == "=" ? K_PCTEQ : K_NONE;
      M_EQ:    return c == "=" ? K_EQEQ : (c == ">" ? K_FATARROW : K_NONE);
      M_BANG:  return c == "=" ? K_BANGEQ : K_NONE;
      M_LT:    return c == "=" ? K_LE : K_NONE;
      M_GT:    return c == "=" ? K_GE : K_NONE;
      M_AMP:   return c == "&" ? K_ANDAND : (c == "=" ? K_AMPEQ : K_NONE);
      M_PIPE:  return c == "|" ? K_OROR : (c == "=" ? K_PIPEEQ : K_NONE);
      M_CARET: return c == "=" ? K_CARETEQ : K_NONE;
      default: return K_NONE;
    endcase
  endfunction

endpackage

// ===== hdl/source_text_tokenizer.sv =====
// source text tokenizer: one byte per transaction, up to three tokens out per byte
// latency: first token of a byte is valid the cycle after the byte is taken
// throughput: one byte per cycle while bytes yield at most one token and the output is not
//   stalled; further tokens hold the input until the three-slot result register drains
// reset (rst, synchronous): scanner idle at offset 0, line 1, column 1, no token pending
// a zero byte flushes the open token, emits EOF and returns the scanner to that state
module source_text_tokenizer #(
  parameter int KEYWORD_MAX_LEN = stt_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS = stt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_stall,
  input  logic [7:0]             text_byte,
  output logic                   token_valid,
  input  logic                   token_stall,
  output stt_pkg::kind_t         token_kind,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [LENGTH_BITS-1:0] token_length,
  output logic [LINE_BITS-1:0]   start_line,
  output logic [COLUMN_BITS-1:0] start_column,
  output logic                   last_of_run
);
  import stt_pkg::*;

  localparam int KBW = 8 * KEYWORD_MAX_LEN;
  localparam int OSW = (OFFSET_BITS > LENGTH_BITS ? OFFSET_BITS : LENGTH_BITS) + 1;
  localparam int CSW = (COLUMN_BITS > LENGTH_BITS ? COLUMN_BITS : LENGTH_BITS) + 1;
  localparam logic [OSW-1:0] OFF_MAX = OSW'({OFFSET_BITS{1'b1}});
  localparam logic [CSW-1:0] COL_MAX = CSW'({COLUMN_BITS{1'b1}});

  typedef struct packed {
    kind_t                  kind;
    logic [OFFSET_BITS-1:0] off;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
  } res_t;

  function automatic logic [LENGTH_BITS-1:0] len_add(input logic [LENGTH_BITS-1:0] v,
                                                     input logic [1:0] d);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, v} + (LENGTH_BITS + 1)'(d);
    return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] off_add(input logic [OFFSET_BITS-1:0] v,
                                                     input logic [LENGTH_BITS-1:0] d);
    logic [OSW-1:0] s;
    s = OSW'(v) + OSW'(d);
    return (s > OFF_MAX) ? {OFFSET_BITS{1'b1}} : s[OFFSET_BITS-1:0];
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_add(input logic [COLUMN_BITS-1:0] v,
                                                     input logic [LENGTH_BITS-1:0] d);
    logic [CSW-1:0] s;
    s = CSW'(v) + CSW'(d);
    return (s > COL_MAX) ? {COLUMN_BITS{1'b1}} : s[COLUMN_BITS-1:0];
  endfunction

  // scanner state
  mode_t                  mode;
  logic [OFFSET_BITS-1:0] cur_offset;
  logic [LINE_BITS-1:0]   cur_line;
  logic [COLUMN_BITS-1:0] cur_column;
  logic [OFFSET_BITS-1:0] tok_start_offset;
  logic [LINE_BITS-1:0]   tok_start_line;
  logic [COLUMN_BITS-1:0] tok_start_column;
  logic [LENGTH_BITS-1:0] tok_length;
  logic [KBW-1:0]         keyword_buffer;
  logic                   float_seen;
  logic                   raw_string;
  logic                   escape_pending;

  mode_t                  mode_next;
  logic [OFFSET_BITS-1:0] cur_offset_next;
  logic [LINE_BITS-1:0]   cur_line_next;
  logic [COLUMN_BITS-1:0] cur_column_next;
  logic [OFFSET_BITS-1:0] tok_start_offset_next;
  logic [LINE_BITS-1:0]   tok_start_line_next;
  logic [COLUMN_BITS-1:0] tok_start_column_next;
  logic [LENGTH_BITS-1:0] tok_length_next;
  logic [KBW-1:0]         keyword_buffer_next;
  logic                   float_seen_next;
  logic                   raw_string_next;
  logic                   escape_pending_next;

  // result register
  res_t       res_q [MAX_RESULTS];
  res_t       res_next [MAX_RESULTS];
  logic [1:0] res_cnt;
  logic [1:0] res_idx;
  logic [1:0] n_next;

  logic in_fire, out_fire, out_last;

  assign token_valid  = (res_cnt != 2'd0);
  assign out_last     = (res_idx == res_cnt - 2'd1);
  assign out_fire     = token_valid && !token_stall;
  assign text_stall   = token_valid && !(out_fire && out_last);
  assign in_fire      = text_valid && !text_stall;
  assign token_kind   = res_q[res_idx].kind;
  assign start_offset = res_q[res_idx].off;
  assign token_length = res_q[res_idx].len;
  assign start_line   = res_q[res_idx].line;
  assign start_column = res_q[res_idx].col;
  assign last_of_run  = out_last;

  always_comb begin
    logic [7:0]             c;
    logic                   done;
    logic                   cons;
    logic                   ev;
    kind_t                  ek;
    kind_t                  pk;
    logic [LENGTH_BITS-1:0] el;
    logic [OFFSET_BITS-1:0] eo;
    logic [LINE_BITS-1:0]   eli;
    logic [COLUMN_BITS-1:0] eco;
    logic                   tail;
    kind_t                  idk;
    c = text_byte;
    mode_next = mode;
    cur_offset_next = cur_offset;
    cur_line_next = cur_line;
    cur_column_next = cur_column;
    tok_start_offset_next = tok_start_offset;
    tok_start_line_next = tok_start_line;
    tok_start_column_next = tok_start_column;
    tok_length_next = tok_length;
    keyword_buffer_next = keyword_buffer;
    float_seen_next = float_seen;
    raw_string_next = raw_string;
    escape_pending_next = escape_pending;
    n_next = 2'd0;
    done = 1'b0;
    cons = 1'b1;
    ev = 1'b0;
    ek = K_NONE;
    pk = K_NONE;
    el = '0;
    eo = '0;
    eli = '0;
    eco = '0;
    tail = 1'b0;
    idk = K_IDENT;
    for (int r = 0; r < MAX_RESULTS; r++) begin
      res_next[r] = res_q[r];
    end

    // identifier kind from the buffer as it stands
    if (tok_length <= LENGTH_BITS'(8)) begin
      idk = kw_kind(keyword_buffer[63:0]);
    end

    if (c == 8'd0) begin
      // end of text: flush the open token
      eo = tok_start_offset;
      eli = tok_start_line;
      eco = tok_start_column;
      el = tok_length;
      ev = 1'b1;
      case (mode)
        M_IDLE, M_SLASH2, M_LINECOM, M_BLOCK, M_BLOCKSTAR: ev = 1'b0;
        M_IDENT: ek = idk;
        M_ZERO, M_DEC, M_FRAC, M_EXPSIGN, M_EXPDIG, M_SUFFIX, M_PREFIXED:
          ek = float_seen ? K_FLOAT : K_INT;
        M_DECDOT: ek = K_INT;
        M_STR, M_CHR: ek = K_ERROR;
        M_DOC: ek = K_DOC;
        M_SHL: begin
          ek = K_SHL;
          el = LENGTH_BITS'(2);
        end
        M_SHR: begin
          ek = K_SHR;
          el = LENGTH_BITS'(2);
        end
        default: begin
          ek = op_single(mode);
          el = LENGTH_BITS'(1);
        end
      endcase
      if (ev) begin
        res_next[n_next] = '{ek, eo, el, eli, eco};
        n_next = n_next + 2'd1;
      end
      if (mode == M_DECDOT) begin
        // the dot after the number stands alone
        res_next[n_next] = '{K_DOT, off_add(tok_start_offset, tok_length),
                             LENGTH_BITS'(1), tok_start_line,
                             col_add(tok_start_column, tok_length)};
        n_next = n_next + 2'd1;
      end
      res_next[n_next] = '{K_EOF, cur_offset, '0, cur_line, cur_column};
      n_next = n_next + 2'd1;
      mode_next = M_IDLE;
      cur_offset_next = '0;
      cur_line_next = LINE_BITS'(1);
      cur_column_next = COLUMN_BITS'(1);
      tok_start_offset_next = '0;
      tok_start_line_next = LINE_BITS'(1);
      tok_start_column_next = COLUMN_BITS'(1);
      tok_length_next = '0;
      keyword_buffer_next = '0;
      float_seen_next = 1'b0;
      raw_string_next = 1'b0;
      escape_pending_next = 1'b0;
    end else begin
      // a byte may end open tokens before it is consumed, at most four passes
      for (int it = 0; it < 4; it++) begin
        if (!done) begin
          cons = 1'b1;
          ev = 1'b0;
          ek = K_NONE;
          el = tok_length_next;
          eo = tok_start_offset_next;
          eli = tok_start_line_next;
          eco = tok_start_column_next;
          tail = 1'b0;
          idk = K_IDENT;
          if (tok_length_next <= LENGTH_BITS'(8)) begin
            idk = kw_kind(keyword_buffer_next[63:0]);
          end
          case (mode_next)
            M_IDLE: begin
              tok_start_offset_next = cur_offset;
              tok_start_line_next = cur_line;
              tok_start_column_next = cur_column;
              tok_length_next = LENGTH_BITS'(1);
              float_seen_next = 1'b0;
              raw_string_next = 1'b0;
              escape_pending_next = 1'b0;
              if (is_space(c)) begin
                mode_next = M_IDLE;
              end else if (is_digit(c)) begin
                mode_next = (c == "0") ? M_ZERO : M_DEC;
              end else if (is_alpha(c)) begin
                keyword_buffer_next = KBW'(c);
                mode_next = M_IDENT;
              end else begin
                mode_next = M_IDLE;
                ek = K_NONE;
                case (c)
                  "\"": mode_next = M_STR;
                  "'":  mode_next = M_CHR;
                  "/":  mode_next = M_SLASH;
                  ".":  mode_next = M_DOT;
                  ":":  mode_next = M_COLON;
                  "-":  mode_next = M_MINUS;
                  "+":  mode_next = M_PLUS;
                  "*":  mode_next = M_STAR;
                  "%":  mode_next = M_PCT;
                  "=":  mode_next = M_EQ;
                  "!":  mode_next = M_BANG;
                  "<":  mode_next = M_LT;
                  ">":  mode_next = M_GT;
                  "&":  mode_next = M_AMP;
                  "|":  mode_next = M_PIPE;
                  "^":  mode_next = M_CARET;
                  "(":  ek = K_LPAREN;
                  ")":  ek = K_RPAREN;
                  "{":  ek = K_LBRACE;
                  "}":  ek = K_RBRACE;
                  "[":  ek = K_LBRACKET;
                  "]":  ek = K_RBRACKET;
                  ",":  ek = K_COMMA;
                  ";":  ek = K_SEMI;
                  "@":  ek = K_AT;
                  "~":  ek = K_TILDE;
                  default: ek = K_ERROR;
                endcase
                if (mode_next == M_IDLE) begin
                  ev = 1'b1;
                  el = LENGTH_BITS'(1);
                  eo = cur_offset;
                  eli = cur_line;
                  eco = cur_column;
                end
              end
            end
            M_IDENT: begin
              if (c == "\"" && tok_length_next == LENGTH_BITS'(1) &&
                  keyword_buffer_next[7:0] == "r") begin
                raw_string_next = 1'b1;
                tok_length_next = len_add(tok_length_next, 2'd1);
                mode_next = M_STR;
              end else if (is_ident(c)) begin
                for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                  if (tok_length_next == LENGTH_BITS'(j)) begin
                    keyword_buffer_next[8*j +: 8] = c;
                  end
                end
                tok_length_next = len_add(tok_length_next, 2'd1);
              end else begin
                ev = 1'b1;
                ek = idk;
                mode_next = M_IDLE;
                cons = 1'b0;
              end
            end
            M_ZERO: begin
              if (c == "x" || c == "X" || c == "b" || c == "B" || c == "o" || c == "O") begin
                tok_length_next = len_add(tok_length_next, 2'd1);
                mode_next = M_PREFIXED;
              end else begin
                mode_next = M_DEC;
                cons = 1'b0;
              end
            end
            M_DEC: begin
              if (is_dec(c)) begin
                tok_length_next = len_add(tok_length_next, 2'd1);
              end else if (c == ".") begin
                mode_next = M_DECDOT;
              end else if (c == "e" || c == "E") begin
                float_seen_next = 1'b1;
                tok_length_next = len_add(tok_length_next, 2'd1);
                mode_next = M_EXPSIGN;
              end else begin
                tail = 1'b1;
              end
            end
            M_DECDOT: begin
              if (is_digit(c)) begin
                float_seen_next = 1'b1;
                tok_length_next = len_add(tok_length_next, 2'd2);
                mode_next = M_FRAC;
              end else begin
                // close the int and reopen at the dot
                ev = 1'b1;
                ek = K_INT;
                tok_start_offset_next = off_add(tok_start_offset_next, tok_length_next);
                tok_start_column_next = col_add(tok_start_column_next, tok_length_next);
                tok_length_next = LENGTH_BITS'(1);
                mode_next = M_DOT;
                cons = 1'b0;
              end
            end
            M_FRAC: begin
              if (is_dec(c)) begin
                tok_length_next = len_add(tok_length_next, 2'd1);
              end else if (c == "e" || c == "E") begin
                tok_length_next = len_add(tok_length_next, 2'd1);
                mode_next = M_EXPSIGN;
              end else begin
                tail = 1'b1;
              end
            end
            M_EXPSIGN: begin
              if (c == "+" || c == "-" || is_dec(c)) begin
                tok_length_next = len_add(tok_length_next, 2'd1);
                mode_next = M_EXPDIG;
              end else begin
                tail = 1'b1;
              end
            end
            M_EXPDIG: begin
              if (is_dec(c)) begin
                tok_length_next = len_add(tok_length_next, 2'd1);
              end else begin
                tail = 1'b1;
              end
            end
            M_SUFFIX, M_PREFIXED: tail = 1'b1;
            M_STR, M_CHR: begin
              tok_length_next = len_add(tok_length_next, 2'd1);
              el = tok_length_next;
              if (escape_pending_next) begin
                escape_pending_next = 1'b0;
              end else if (!raw_string_next && c == "\\") begin
                escape_pending_next = 1'b1;
              end else if (mode_next == M_STR && c == "\"") begin
                ev = 1'b1;
                ek = K_STRING;
                mode_next = M_IDLE;
              end else if (mode_next == M_CHR && c == "'") begin
                ev = 1'b1;
                ek = K_CHAR;
                mode_next = M_IDLE;
              end
            end
            M_SLASH: begin
              if (c == "/") begin
                tok_length_next = len_add(tok_length_next, 2'd1);
                mode_next = M_SLASH2;
              end else if (c == "*") begin
                mode_next = M_BLOCK;
              end else if (c == "=") begin
                ev = 1'b1;
                ek = K_SLASHEQ;
                el = LENGTH_BITS'(2);
                mode_next = M_IDLE;
              end else begin
                ev = 1'b1;
                ek = K_SLASH;
                el = LENGTH_BITS'(1);
                mode_next = M_IDLE;
                cons = 1'b0;
              end
            end
            M_SLASH2: begin
              if (c == "/") begin
                tok_length_next = len_add(tok_length_next, 2'd1);
                mode_next = M_DOC;
              end else begin
                mode_next = (c == "\n") ? M_IDLE : M_LINECOM;
              end
            end
            M_LINECOM: begin
              if (c == "\n") begin
                mode_next = M_IDLE;
              end
            end
            M_DOC: begin
              if (c == "\n") begin
                ev = 1'b1;
                ek = K_DOC;
                mode_next = M_IDLE;
              end else begin
                tok_length_next = len_add(tok_length_next, 2'd1);
              end
            end
            M_BLOCK: begin
              if (c == "*") begin
                mode_next = M_BLOCKSTAR;
              end
            end
            M_BLOCKSTAR: begin
              mode_next = (c == "/") ? M_IDLE : ((c == "*") ? M_BLOCKSTAR : M_BLOCK);
            end
            M_SHL, M_SHR: begin
              ev = 1'b1;
              if (c == "=") begin
                ek = (mode_next == M_SHL) ? K_SHLEQ : K_SHREQ;
                el = LENGTH_BITS'(3);
              end else begin
                ek = (mode_next == M_SHL) ? K_SHL : K_SHR;
                el = LENGTH_BITS'(2);
                cons = 1'b0;
              end
              mode_next = M_IDLE;
            end
            default: begin
              if (mode_next == M_LT && c == "<") begin
                mode_next = M_SHL;
              end else if (mode_next == M_GT && c == ">") begin
                mode_next = M_SHR;
              end else begin
                pk = op_pair(mode_next, c);
                ev = 1'b1;
                if (pk != K_NONE) begin
                  ek = pk;
                  el = LENGTH_BITS'(2);
                end else begin
                  ek = op_single(mode_next);
                  el = LENGTH_BITS'(1);
                  cons = 1'b0;
                end
                mode_next = M_IDLE;
              end
            end
          endcase
          // number modes: identifier bytes go to the suffix, others end the number
          if (tail) begin
            if (is_ident(c)) begin
              tok_length_next = len_add(tok_length_next, 2'd1);
              mode_next = M_SUFFIX;
            end else begin
              ev = 1'b1;
              ek = float_seen_next ? K_FLOAT : K_INT;
              el = tok_length_next;
              mode_next = M_IDLE;
              cons = 1'b0;
            end
          end
          if (ev && n_next != 2'd3) begin
            res_next[n_next] = '{ek, eo, el, eli, eco};
            n_next = n_next + 2'd1;
          end
          done = cons;
        end
      end
      if (cur_offset != {OFFSET_BITS{1'b1}}) begin
        cur_offset_next = cur_offset + OFFSET_BITS'(1);
      end
      if (c == "\n") begin
        if (cur_line != {LINE_BITS{1'b1}}) begin
          cur_line_next = cur_line + LINE_BITS'(1);
        end
        cur_column_next = COLUMN_BITS'(1);
      end else if (cur_column != {COLUMN_BITS{1'b1}}) begin
        cur_column_next = cur_column + COLUMN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      cur_offset <= '0;
      cur_line <= LINE_BITS'(1);
      cur_column <= COLUMN_BITS'(1);
      tok_start_offset <= '0;
      tok_start_line <= LINE_BITS'(1);
      tok_start_column <= COLUMN_BITS'(1);
      tok_length <= '0;
      keyword_buffer <= '0;
      float_seen <= 1'b0;
      raw_string <= 1'b0;
      escape_pending <= 1'b0;
      res_cnt <= 2'd0;
      res_idx <= 2'd0;
    end else begin
      if (out_fire) begin
        if (out_last) begin
          res_cnt <= 2'd0;
          res_idx <= 2'd0;
        end else begin
          res_idx <= res_idx + 2'd1;
        end
      end
      if (in_fire) begin
        mode <= mode_next;
        cur_offset <= cur_offset_next;
        cur_line <= cur_line_next;
        cur_column <= cur_column_next;
        tok_start_offset <= tok_start_offset_next;
        tok_start_line <= tok_start_line_next;
        tok_start_column <= tok_start_column_next;
        tok_length <= tok_length_next;
        keyword_buffer <= keyword_buffer_next;
        float_seen <= float_seen_next;
        raw_string <= raw_string_next;
        escape_pending <= escape_pending_next;
        if (n_next != 2'd0) begin
          res_cnt <= n_next;
          res_idx <= 2'd0;
        end
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && n_next != 2'd0) begin
      for (int r = 0; r < MAX_RESULTS; r++) begin
        res_q[r] <= res_next[r];
      end
    end
  end

endmodule

// ===== hdl/stt_checker.sv =====
// port-level checks for the source text tokenizer, bound to the top level
module stt_checker #(
  parameter int KEYWORD_MAX_LEN = stt_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS = stt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   text_valid,
  input logic                   text_stall,
  input logic [7:0]             text_byte,
  input logic                   token_valid,
  input logic                   token_stall,
  input stt_pkg::kind_t         token_kind,
  input logic [OFFSET_BITS-1:0] start_offset,
  input logic [LENGTH_BITS-1:0] token_length,
  input logic [LINE_BITS-1:0]   start_line,
  input logic [COLUMN_BITS-1:0] start_column,
  input logic                   last_of_run
);
  import stt_pkg::*;

  // a stalled transaction stays offered with the same kind, offset, length and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token_kind) &&
      $stable(start_offset) && $stable(token_length) && $stable(last_of_run))
    else $error("stalled token changed");

  // the input waits only behind pending tokens
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> token_valid)
    else $error("input stalled with no token pending");

  // end of text always yields a token next cycle
  a_eof_out: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_stall && text_byte == 8'd0 |=> token_valid)
    else $error("no token after end of text");

  // EOF is empty and closes its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_kind == K_EOF |-> last_of_run && token_length == '0)
    else $error("bad EOF token");

endmodule

bind source_text_tokenizer stt_checker #(
  .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
  .LENGTH_BITS(LENGTH_BITS),
  .LINE_BITS(LINE_BITS),
  .COLUMN_BITS(COLUMN_BITS),
  .OFFSET_BITS(OFFSET_BITS)
) u_stt_checker (.*);
